### rtl/prw_pkg.sv
`timescale 1ns / 1ps
package prw_pkg;

  localparam int SLOTS    = 4;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SEQ_BITS = 16;
  localparam int TMO_W    = 20;
  localparam int STAT_W   = 16;
  localparam int QDEPTH   = 2;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(500000);
  localparam logic [31:0]      LFSR_TAPS     = 32'h8020_0003;
  localparam logic [31:0]      LFSR_SEED     = 32'h0000_0001;

  localparam logic CFG_LAST_SEQ = 1'b0;
  localparam logic CFG_TIMEOUT  = 1'b1;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_KICK  = 2'd1,
    FUNC_RECV  = 2'd2,
    FUNC_TICK  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_NEW   = 2'd0,
    KIND_RETRY = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef struct packed {
    func_t                op;
    logic [SLOT_W-1:0]    slot;
    logic [SEQ_BITS-1:0]  seq;
  } cmd_t;

  function automatic logic [31:0] lfsr_step(input logic [31:0] v);
    lfsr_step = (v >> 1) ^ (v[0] ? LFSR_TAPS : 32'd0);
  endfunction

  function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
    sat_inc = (&v) ? v : v + STAT_W'(1);
  endfunction

endpackage

### rtl/prw_front.sv
`timescale 1ns / 1ps
module prw_front (
  input  logic                     start,
  input  logic [1:0]               func,
  input  logic [1:0]               slot_index,
  input  logic [15:0]              seq_num,
  input  logic                     name_matches,
  input  logic                     q_full,
  output logic                     busy,
  output logic                     push,
  output prw_pkg::cmd_t            push_cmd
);
  import prw_pkg::*;

  logic accept;
  logic keep;

  assign busy   = q_full;
  assign accept = start && !q_full;

  // drop items that can have no effect: kicks beyond the slots, foreign names
  always_comb begin
    keep = 1'b1;
    unique case (func_t'(func))
      FUNC_KICK:  keep = (32'(slot_index) < SLOTS);
      FUNC_RECV:  keep = name_matches;
      default:    keep = 1'b1;
    endcase
  end

  assign push          = accept && keep;
  assign push_cmd.op   = func_t'(func);
  assign push_cmd.slot = SLOT_W'(slot_index);
  assign push_cmd.seq  = SEQ_BITS'(seq_num);

endmodule

### rtl/prw_queue.sv
`timescale 1ns / 1ps
module prw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  prw_pkg::cmd_t push_cmd,
  input  logic          pop,
  output prw_pkg::cmd_t pop_cmd,
  output logic          empty,
  output logic          full
);
  import prw_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             entries [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(QDEPTH));
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

### rtl/prw_back.sv
`timescale 1ns / 1ps
module prw_back (
  input  logic                        clk,
  input  logic                        rst,
  input  prw_pkg::cmd_t               q_cmd,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  logic [15:0]                 last_sequence,
  input  logic [19:0]                 timeout_ticks,
  output logic                        valid,
  output logic [1:0]                  kind,
  output logic [1:0]                  req_slot,
  output logic [15:0]                 req_seq,
  output logic [31:0]                 req_nonce,
  output logic [15:0]                 out_of_order_count,
  output logic [15:0]                 retry_count,
  output logic [15:0]                 received_count,
  output logic                        last
);
  import prw_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t              state, state_next;
  cmd_t                cmd;
  logic [SLOT_W-1:0]   cur, cur_next;

  logic [SEQ_BITS-1:0] slot_seq       [SLOTS];
  logic [SEQ_BITS-1:0] slot_seq_next  [SLOTS];
  logic [TMO_W-1:0]    slot_cd        [SLOTS];
  logic [TMO_W-1:0]    slot_cd_next   [SLOTS];
  logic [SLOTS-1:0]    slot_busy, slot_busy_next;

  logic [SEQ_BITS:0]   next_seq, next_seq_next;
  logic [SEQ_BITS:0]   prev_rx, prev_rx_next;
  logic [2:0]          active_slots, active_slots_next;
  logic [31:0]         lfsr, lfsr_next;
  logic [STAT_W-1:0]   ooo, ooo_next, retries, retries_next, recv, recv_next;

  logic                match_found;
  logic [SLOT_W-1:0]   match_idx;
  logic [SLOT_W-1:0]   sel;
  logic                later_idle, later_expire;
  logic                window_open, window_open_after;
  logic [TMO_W-1:0]    tload;
  logic                finishing;

  logic                emit, e_last;
  kind_t               e_kind;
  logic [SEQ_BITS-1:0] e_seq;
  logic [31:0]         e_nonce;

  assign tload             = (timeout_ticks == '0) ? TMO_W'(1) : timeout_ticks;
  assign window_open       = (next_seq <= {1'b0, last_sequence});
  assign window_open_after = ((next_seq + (SEQ_BITS+1)'(1)) <= {1'b0, last_sequence});

  always_comb begin
    match_found  = 1'b0;
    match_idx    = '0;
    later_idle   = 1'b0;
    later_expire = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_busy[i] && slot_seq[i] == cmd.seq) begin
        match_found = 1'b1;
        match_idx   = SLOT_W'(i);
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (SLOT_W'(i) > cur) begin
        if (!slot_busy[i]) later_idle = 1'b1;
        if (slot_busy[i] && slot_cd[i] <= TMO_W'(1)) later_expire = 1'b1;
      end
    end
  end

  assign sel       = (cmd.op == FUNC_RECV) ? match_idx : cur;
  assign finishing = (state == ST_RUN) &&
                     ((cmd.op == FUNC_KICK) || (cmd.op == FUNC_RECV) ||
                      (cur == SLOT_W'(SLOTS - 1)));
  assign q_pop     = !q_empty && ((state == ST_IDLE) || finishing);

  always_comb begin
    slot_seq_next      = slot_seq;
    slot_cd_next       = slot_cd;
    slot_busy_next     = slot_busy;
    next_seq_next      = next_seq;
    prev_rx_next       = prev_rx;
    active_slots_next  = active_slots;
    lfsr_next          = lfsr;
    ooo_next           = ooo;
    retries_next       = retries;
    recv_next          = recv;
    emit               = 1'b0;
    e_last             = 1'b1;
    e_kind             = KIND_NEW;
    e_seq              = slot_seq[sel];
    e_nonce            = lfsr_step(lfsr);

    if (state == ST_RUN) begin
      case (cmd.op)
        FUNC_START, FUNC_KICK: begin
          if (!slot_busy[sel] && window_open) begin
            slot_busy_next[sel] = 1'b1;
            if (active_slots < 3'd7) active_slots_next = active_slots + 3'd1;
            slot_seq_next[sel]  = next_seq[SEQ_BITS-1:0];
            slot_cd_next[sel]   = tload;
            next_seq_next       = next_seq + (SEQ_BITS+1)'(1);
            lfsr_next           = lfsr_step(lfsr);
            emit                = 1'b1;
            e_seq               = next_seq[SEQ_BITS-1:0];
            e_last              = (cmd.op == FUNC_KICK) ||
                                  !(later_idle && window_open_after);
          end
        end
        FUNC_RECV: begin
          if (match_found) begin
            recv_next = sat_inc(recv);
            if ({1'b0, cmd.seq} != prev_rx + (SEQ_BITS+1)'(1)) begin
              ooo_next = sat_inc(ooo);
            end
            prev_rx_next = {1'b0, cmd.seq};
            if (!window_open) begin
              slot_busy_next[sel] = 1'b0;
              slot_cd_next[sel]   = '0;
              if (active_slots != 3'd0) active_slots_next = active_slots - 3'd1;
              if (active_slots_next == 3'd0) begin
                emit    = 1'b1;
                e_kind  = KIND_DONE;
                e_seq   = cmd.seq;
                e_nonce = '0;
              end
            end else begin
              slot_seq_next[sel] = next_seq[SEQ_BITS-1:0];
              slot_cd_next[sel]  = tload;
              next_seq_next      = next_seq + (SEQ_BITS+1)'(1);
              lfsr_next          = lfsr_step(lfsr);
              emit               = 1'b1;
              e_seq              = next_seq[SEQ_BITS-1:0];
            end
          end
        end
        default: begin
          if (slot_busy[sel]) begin
            if (slot_cd[sel] <= TMO_W'(1)) begin
              retries_next      = sat_inc(retries);
              slot_cd_next[sel] = tload;
              lfsr_next         = lfsr_step(lfsr);
              emit              = 1'b1;
              e_kind            = KIND_RETRY;
              e_last            = !later_expire;
            end else begin
              slot_cd_next[sel] = slot_cd[sel] - TMO_W'(1);
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    cur_next   = cur;
    if (q_pop) begin
      state_next = ST_RUN;
      cur_next   = (q_cmd.op == FUNC_KICK) ? q_cmd.slot : '0;
    end else if (finishing) begin
      state_next = ST_IDLE;
    end else if (state == ST_RUN) begin
      cur_next = cur + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
    end
    cur       <= cur_next;
    slot_seq  <= slot_seq_next;
    kind      <= e_kind;
    req_slot  <= 2'(sel);
    req_seq   <= e_seq;
    req_nonce <= e_nonce;
    last      <= e_last;
    out_of_order_count <= ooo_next;
    retry_count        <= retries_next;
    received_count     <= recv_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      slot_busy     <= '0;
      next_seq      <= '0;
      prev_rx       <= '1;
      active_slots  <= '0;
      lfsr          <= LFSR_SEED;
      ooo           <= '0;
      retries       <= '0;
      recv          <= '0;
      valid         <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_cd[i] <= '0;
      end
    end else begin
      state         <= state_next;
      slot_busy     <= slot_busy_next;
      slot_cd       <= slot_cd_next;
      next_seq      <= next_seq_next;
      prev_rx       <= prev_rx_next;
      active_slots  <= active_slots_next;
      lfsr          <= lfsr_next;
      ooo           <= ooo_next;
      retries       <= retries_next;
      recv          <= recv_next;
      valid         <= emit;
    end
  end

endmodule

### rtl/pipelined_request_window.sv
`timescale 1ns / 1ps
// Request window: four slots keep segment requests outstanding.
// Event channel: drive func/slot_index/seq_num/name_matches with start high;
// the transfer happens at an edge where start is high and busy is low.
// busy rises only when the two-entry event queue is full.
// Result channel: valid marks each result for exactly one cycle; last flags
// the final result of an event. The receiver cannot stall, so nothing waits.
// An event taken while the back end is free passes the queue, then one slot
// step, then the output register, before its result appears.
// Start and tick events visit every slot, one per cycle; kick and
// received-segment events visit a single slot. Events that can have no
// effect (foreign names, kicks past the slots) never enter the queue.
// Registers on the APB port: 0x0 last_sequence, 0x4 timeout_ticks. Write them
// only while no event is in flight.
// Reset (rst, synchronous) empties the queue, frees all slots, clears the
// statistics, seeds the nonce generator with 1 and restores the registers.
module pipelined_request_window (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [1:0]  slot_index,
  input  logic [15:0] seq_num,
  input  logic        name_matches,
  output logic        valid,
  output logic [1:0]  kind,
  output logic [1:0]  req_slot,
  output logic [15:0] req_seq,
  output logic [31:0] req_nonce,
  output logic [15:0] out_of_order_count,
  output logic [15:0] retry_count,
  output logic [15:0] received_count,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import prw_pkg::*;

  logic [15:0]      last_sequence;
  logic [TMO_W-1:0] timeout_ticks;
  logic             cfg_write;

  logic             q_full, q_empty, push, pop;
  cmd_t             push_cmd, pop_cmd;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sequence <= '0;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == CFG_LAST_SEQ) last_sequence <= pwdata[15:0];
      else                          timeout_ticks <= pwdata[TMO_W-1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_TIMEOUT) ? {{(32-TMO_W){1'b0}}, timeout_ticks}
                                            : {16'd0, last_sequence};

  prw_front u_front (
    .start        (start),
    .func         (func),
    .slot_index   (slot_index),
    .seq_num      (seq_num),
    .name_matches (name_matches),
    .q_full       (q_full),
    .busy         (busy),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  prw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  prw_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_cmd              (pop_cmd),
    .q_empty            (q_empty),
    .q_pop              (pop),
    .last_sequence      (last_sequence),
    .timeout_ticks      (timeout_ticks),
    .valid              (valid),
    .kind               (kind),
    .req_slot           (req_slot),
    .req_seq            (req_seq),
    .req_nonce          (req_nonce),
    .out_of_order_count (out_of_order_count),
    .retry_count        (retry_count),
    .received_count     (received_count),
    .last               (last)
  );

endmodule
